/* src/hem_pkg.sv */
// hem_pkg: shared types, register codes and fixed field widths of the evolvent map
// depends on nothing; used by hem_cfg_if and every module of the block
package hem_pkg;

    localparam int DIMS_W     = 4;
    localparam int LEVELS_W   = 6;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIMS   = 2'd0,
        CFG_LEVELS = 2'd1,
        CFG_MODE   = 2'd2
    } hem_cfg_idx_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_CENTER = 2'd0,
        MODE_LINEAR = 2'd1,
        MODE_NODE   = 2'd2
    } hem_mode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_ALIGN,
        S_LEVEL,
        S_FIX,
        S_OUT
    } hem_state_t;

    // walk state carried from level to level: entry axis and correction axis
    typedef struct packed {
        logic [DIMS_W-1:0] it;
        logic [DIMS_W-1:0] k;
    } hem_walk_t;

    typedef struct packed {
        logic busy;
        logic done;
    } hem_div_stat_t;

endpackage

/* src/hem_if.sv */
// hem_in_if, hem_out_if, hem_cfg_if: valid/ready channels of the evolvent map
// depends on hem_pkg for the configuration field widths
interface hem_in_if #(
    parameter int XW = 49
);
    logic          valid;
    logic          ready;
    logic [XW-1:0] x_position;

    modport source (output valid, output x_position, input ready);
    modport sink   (input valid, input x_position, output ready);
endinterface

interface hem_out_if #(
    parameter int VW = 49
);
    logic                 valid;
    logic                 ready;
    logic [3:0]           coord_index;
    logic signed [VW-1:0] coord_value;
    logic                 last;
    logic                 bad_setting;

    modport source (output valid, output coord_index, output coord_value,
                    output last, output bad_setting, input ready);
    modport sink   (input valid, input coord_index, input coord_value,
                    input last, input bad_setting, output ready);
endinterface

interface hem_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [hem_pkg::CFG_IDX_W-1:0]  index;
    logic [hem_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/hem_level.sv */
// hem_level: one partition level of the curve, sub-cube pattern, swap and orientation
// depends on hem_pkg for the walk struct and field widths
module hem_level #(
    parameter int MAX_DIMS = 10
) (
    input  logic [MAX_DIMS-1:0]      digit,
    input  logic [hem_pkg::DIMS_W-1:0] dims,
    input  logic [MAX_DIMS-1:0]      w_in,
    input  hem_pkg::hem_walk_t       walk_in,
    output logic [MAX_DIMS-1:0]      u_out,
    output logic [MAX_DIMS-1:0]      w_out,
    output hem_pkg::hem_walk_t       walk_out
);
    import hem_pkg::*;

    localparam int IW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    logic [MAX_DIMS-1:0] dmask, cur, lowm, u_p, v_p, u_s, v_s;
    logic [DIMS_W-1:0]   nm1, ax, ax_r;
    logic                q_pos, q_neg, is_zero, is_full, prev;

    // bit set means +1, clear means -1
    always_comb
    begin
        nm1   = dims - 1'b1;
        dmask = '0;
        cur   = '0;
        for (int i = 0; i < MAX_DIMS; i++)
        begin
            if (i < int'(dims))
            begin
                dmask[i] = 1'b1;
                cur[i]   = digit[IW'(int'(nm1) - i)];
            end
        end
        is_zero = (digit & dmask) == '0;
        is_full = (digit & dmask) == dmask;

        // exit axis: lowest bit position that opens or closes a run
        ax    = nm1;
        q_pos = 1'b0;
        q_neg = 1'b0;
        lowm  = '0;
        if (!is_zero && !is_full)
        begin
            for (int p = MAX_DIMS - 1; p >= 1; p--)
            begin
                lowm = MAX_DIMS'((1 << p) - 1);
                if (p < int'(dims))
                begin
                    if (digit[p] && ((digit & lowm) == '0))
                    begin
                        ax    = DIMS_W'(int'(nm1) - p);
                        q_neg = 1'b1;
                        q_pos = 1'b0;
                    end
                    else if (!digit[p] && ((digit & lowm) == lowm))
                    begin
                        ax    = DIMS_W'(int'(nm1) - p);
                        q_pos = 1'b1;
                        q_neg = 1'b0;
                    end
                end
            end
        end

        u_p  = '0;
        v_p  = '0;
        prev = 1'b0;
        if (is_zero)
        begin
            u_p = '0;
            v_p = '0;
        end
        else if (is_full)
        begin
            u_p[0]          = 1'b1;
            v_p[0]          = 1'b1;
            v_p[nm1[IW-1:0]] = 1'b1;
        end
        else
        begin
            for (int i = 0; i < MAX_DIMS; i++)
            begin
                u_p[i] = cur[i] ^ prev;
                prev   = cur[i];
            end
            v_p = u_p;
            if (q_neg)
                v_p[ax[IW-1:0]] = ~v_p[ax[IW-1:0]];
            v_p[nm1[IW-1:0]] = ~v_p[nm1[IW-1:0]];
        end

        // exchange coordinate zero with the entry axis
        u_s = u_p;
        v_s = v_p;
        u_s[0]                  = u_p[walk_in.it[IW-1:0]];
        u_s[walk_in.it[IW-1:0]] = u_p[0];
        v_s[0]                  = v_p[walk_in.it[IW-1:0]];
        v_s[walk_in.it[IW-1:0]] = v_p[0];

        if (ax == '0)
            ax_r = walk_in.it;
        else if (ax == walk_in.it)
            ax_r = '0;
        else
            ax_r = ax;

        walk_out.it = ax_r;
        if (q_pos || (!q_neg && is_zero))
            walk_out.k = ax_r;
        else if (q_neg)
            walk_out.k = (walk_in.it == nm1) ? '0 : nm1;
        else
            walk_out.k = walk_in.k;

        u_out = ~(u_s ^ w_in);
        w_out = v_s ^ w_in;
    end

endmodule

/* src/hem_divider.sv */
// hem_divider: restoring divider, one quotient bit per cycle
// depends on hem_pkg for the status struct
module hem_divider #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quot,
    output hem_pkg::hem_div_stat_t stat
);
    import hem_pkg::*;

    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg, den_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg, done_reg;
    logic [DEN_W:0]   trial, diff;
    logic             take;

    always_comb
    begin
        trial = {rem_reg, quo_reg[NUM_W-1]};
        diff  = trial - {1'b0, den_reg};
        take  = trial >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NUM_W-2:0], take};
            rem_reg <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign quot      = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

/* src/hilbert_evolvent_map_top.sv */
// hilbert_evolvent_map_top: space-filling curve map, position in, one item per coordinate out
// depends on hem_pkg, hem_if, hem_level and hem_divider
//
// Maps a curve position (unsigned fraction, 2^FRAC_BITS means one) onto a point of
// [-0.5,0.5]^dims of the Hilbert-type evolvent. One position is worked at a time and
// the input is not ready while it is in flight. Steps per position: capture, form the
// curve index, align it, one pass per level through the shared level unit, one
// correction step, then one output item per cycle while the sink keeps up. Node mode
// (mode 2) adds a pass through the bit-serial divider when the scaled index is non-zero.
// A finished item sits in the output register, so the next position is taken while the
// last coordinate still waits. Unusable settings give dims items (clamped) with
// bad_setting high and value zero. Configuration writes are taken at any time and
// must only be made while the block is idle.
module hilbert_evolvent_map_top #(
    parameter int MAX_DIMS  = 10,
    parameter int FRAC_BITS = 48
) (
    input  logic        clk,
    input  logic        rst_n,
    hem_in_if.sink      pos,
    hem_out_if.source   coord,
    hem_cfg_if.sink     cfg
);
    import hem_pkg::*;

    localparam int FB = FRAC_BITS;
    localparam int YW = FB + 2;                  // accumulator, one extra fraction bit
    localparam int PW = 2 * FB;                  // scaled position product
    localparam int TW = $clog2(FB + 1);
    localparam int CW = $clog2(MAX_DIMS + 1);

    // configuration registers
    logic [DIMS_W-1:0]   dims_reg;
    logic [LEVELS_W-1:0] levels_reg;
    logic [MODE_W-1:0]   mode_reg;

    hem_state_t state_reg, state_next;

    // per-position working registers
    logic [FB:0]          x_reg;
    logic [FB-1:0]        s_reg, dd_reg, frac_reg;
    logic [MAX_DIMS-1:0]  digit_reg, u_reg, w_reg;
    hem_walk_t            walk_reg;
    logic [YW-1:0]        step_reg;
    logic signed [YW-1:0] y_reg [MAX_DIMS];
    logic [LEVELS_W-1:0]  lev_reg;
    logic [CW-1:0]        nres_reg, out_cnt_reg;
    logic                 bad_reg;

    // output register
    logic                 out_valid_reg;
    logic [3:0]           out_idx_reg;
    logic signed [FB:0]   out_val_reg;
    logic                 out_last_reg, out_bad_reg;

    // decoded settings
    logic [9:0]          t_full;
    logic [TW-1:0]       t;
    logic                bad_now;
    logic [CW-1:0]       nres_now;
    hem_mode_t           md;

    // datapath wires
    logic                x_one;
    logic [FB-1:0]       xf, s_center, s_full;
    logic [PW-1:0]       wide_a, wide_b, wide_d;
    logic [MAX_DIMS-1:0] den, digit_now, u_lev, w_lev;
    hem_walk_t           walk_lev;
    logic [FB-1:0]       quot;
    hem_div_stat_t       div_stat;
    logic                div_start;
    logic [FB:0]         corr;
    logic                corr_sub;
    logic [YW-1:0]       node_step;
    logic signed [YW-1:0] r_val;
    logic                load_out, in_take;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg   <= DIMS_W'(2);
            levels_reg <= LEVELS_W'(10);
            mode_reg   <= MODE_CENTER;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_DIMS:   dims_reg   <= cfg.data[DIMS_W-1:0];
                CFG_LEVELS: levels_reg <= cfg.data[LEVELS_W-1:0];
                CFG_MODE:   mode_reg   <= cfg.data[MODE_W-1:0];
                default:    ;
            endcase
        end
    end

    // settings decode
    always_comb
    begin
        t_full  = {6'b0, dims_reg} * {4'b0, levels_reg};
        t       = t_full[TW-1:0];
        bad_now = (dims_reg == '0) || (int'(dims_reg) > MAX_DIMS) ||
                  (levels_reg == '0) || (int'(t_full) > FB);
        if (dims_reg == '0)
            nres_now = CW'(1);
        else if (int'(dims_reg) > MAX_DIMS)
            nres_now = CW'(MAX_DIMS);
        else
            nres_now = CW'(dims_reg);
        case (mode_reg)
            MODE_LINEAR: md = MODE_LINEAR;
            MODE_NODE:   md = MODE_NODE;
            default:     md = MODE_CENTER;
        endcase
    end

    // curve index from the position: center truncates, linear scales by 2^t-1,
    // node scales by 2^t-2^(t-dims)
    always_comb
    begin
        x_one    = x_reg[FB];
        xf       = x_reg[FB-1:0];
        s_center = xf >> (FB - int'(t));
        s_full   = ~({FB{1'b1}} << t);
        wide_a   = {{FB{1'b0}}, xf} << t;
        if (md == MODE_LINEAR)
            wide_b = {{FB{1'b0}}, xf};
        else
            wide_b = {{FB{1'b0}}, xf} << (int'(t) - int'(dims_reg));
        wide_d   = wide_a - wide_b;
        den      = ~({MAX_DIMS{1'b1}} << dims_reg);
        digit_now = MAX_DIMS'(s_reg >> (FB - int'(dims_reg)));
    end

    // linear-mode correction and node offset
    always_comb
    begin
        if (levels_reg == LEVELS_W'(1))
            corr = {1'b0, frac_reg};
        else
            corr = ({1'b0, frac_reg} + ((FB+1)'(1) << (int'(levels_reg) - 2)))
                   >> (int'(levels_reg) - 1);
        corr_sub  = u_reg[walk_reg.k] ^ (digit_reg == den);
        node_step = YW'(1) << (FB - int'(levels_reg));
        r_val     = y_reg[0] + YW'(1);
    end

    hem_level #(
        .MAX_DIMS (MAX_DIMS)
    ) u_level (
        .digit    (digit_now),
        .dims     (dims_reg),
        .w_in     (w_reg),
        .walk_in  (walk_reg),
        .u_out    (u_lev),
        .w_out    (w_lev),
        .walk_out (walk_lev)
    );

    // the divider captures its operands in the same cycle that dd_reg is loaded
    hem_divider #(
        .NUM_W (FB),
        .DEN_W (MAX_DIMS)
    ) u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (wide_d[PW-1:FB] - 1'b1),
        .den   (den),
        .quot  (quot),
        .stat  (div_stat)
    );

    assign pos.ready = (state_reg == S_IDLE);
    assign in_take   = pos.valid && pos.ready;
    assign load_out  = (state_reg == S_OUT) && (!out_valid_reg || coord.ready);
    assign div_start = (state_reg == S_PREP) && !bad_reg && !x_one &&
                       (md == MODE_NODE) && (wide_d[PW-1:FB] != '0);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_take)
                    state_next = S_PREP;
            S_PREP:
                if (bad_reg)
                    state_next = S_OUT;
                else if (div_start)
                    state_next = S_DIV;
                else
                    state_next = S_ALIGN;
            S_DIV:
                if (div_stat.done)
                    state_next = S_ALIGN;
            S_ALIGN:
                state_next = S_LEVEL;
            S_LEVEL:
                if (lev_reg == LEVELS_W'(1))
                    state_next = S_FIX;
            S_FIX:
                state_next = S_OUT;
            S_OUT:
                if (load_out && (out_cnt_reg == nres_reg - 1'b1))
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (coord.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
                if (in_take)
                begin
                    // saturate above one
                    if (pos.x_position > {1'b1, {FB{1'b0}}})
                        x_reg <= {1'b1, {FB{1'b0}}};
                    else
                        x_reg <= pos.x_position;
                    bad_reg     <= bad_now;
                    nres_reg    <= nres_now;
                    out_cnt_reg <= '0;
                    w_reg       <= '1;
                    u_reg       <= '0;
                    walk_reg    <= '0;
                    lev_reg     <= levels_reg;
                    step_reg    <= YW'(1) << (FB - 1);
                    for (int i = 0; i < MAX_DIMS; i++)
                        y_reg[i] <= '0;
                end
            S_PREP:
            begin
                frac_reg <= '0;
                dd_reg   <= wide_d[PW-1:FB];
                if (x_one)
                    s_reg <= s_full;
                else if (md == MODE_LINEAR)
                begin
                    s_reg    <= wide_d[PW-1:FB];
                    frac_reg <= wide_d[FB-1:0];
                end
                else if (md == MODE_NODE)
                    s_reg <= wide_d[PW-1:FB];
                else
                    s_reg <= s_center;
            end
            S_DIV:
                if (div_stat.done)
                    s_reg <= dd_reg + quot;
            S_ALIGN:
                s_reg <= s_reg << (FB - int'(t));
            S_LEVEL:
            begin
                s_reg     <= s_reg << dims_reg;
                digit_reg <= digit_now;
                u_reg     <= u_lev;
                w_reg     <= w_lev;
                walk_reg  <= walk_lev;
                lev_reg   <= lev_reg - 1'b1;
                step_reg  <= step_reg >> 1;
                for (int i = 0; i < MAX_DIMS; i++)
                    if (i < int'(dims_reg))
                        y_reg[i] <= u_lev[i] ? y_reg[i] + step_reg : y_reg[i] - step_reg;
            end
            S_FIX:
                for (int i = 0; i < MAX_DIMS; i++)
                begin
                    if (md == MODE_LINEAR)
                    begin
                        if (i == int'(walk_reg.k))
                            y_reg[i] <= corr_sub ? y_reg[i] - {1'b0, corr}
                                                 : y_reg[i] + {1'b0, corr};
                    end
                    else if (md == MODE_NODE)
                    begin
                        if (i < int'(dims_reg))
                            y_reg[i] <= u_reg[i] ? y_reg[i] + node_step
                                                 : y_reg[i] - node_step;
                    end
                end
            S_OUT:
                if (load_out)
                begin
                    out_idx_reg  <= 4'(out_cnt_reg);
                    out_val_reg  <= bad_reg ? '0 : r_val[FB+1:1];
                    out_last_reg <= (out_cnt_reg == nres_reg - 1'b1);
                    out_bad_reg  <= bad_reg;
                    out_cnt_reg  <= out_cnt_reg + 1'b1;
                    // shift the coordinates down so the next one sits at the head
                    for (int i = 0; i < MAX_DIMS - 1; i++)
                        y_reg[i] <= y_reg[i+1];
                end
            default:
                ;
        endcase
    end

    assign coord.valid       = out_valid_reg;
    assign coord.coord_index = out_idx_reg;
    assign coord.coord_value = out_val_reg;
    assign coord.last        = out_last_reg;
    assign coord.bad_setting = out_bad_reg;

endmodule

/* tb/tb_hilbert_evolvent_map_top.sv */
// tb_hilbert_evolvent_map_top: self-checking bench for the evolvent map, coordinates checked
// against a bit-exact predictor; depends on hem_pkg, hem_if and hilbert_evolvent_map_top
module tb_hilbert_evolvent_map_top;
    import hem_pkg::*;

    localparam int NDIM  = 10;
    localparam int FB    = 48;
    localparam int XW    = FB + 1;
    localparam logic [XW-1:0] POS_ONE = 49'h1_0000_0000_0000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;   // index with no register behind it
    localparam longint CYCLE_LIMIT = 2000000;
    localparam int SETTLE_CYCLES = 200;   // levels + dims + divider pass, with margin
    localparam int HOLD_CYCLES   = 400;

    typedef struct {
        logic [3:0]    idx;
        logic [XW-1:0] value;
        logic          last;
        logic          bad;
    } coord_t;

    // one directed row: settings, position, and whether the answer is known by eye
    typedef struct {
        logic [3:0]    dims;
        logic [5:0]    levels;
        logic [1:0]    mode;
        logic [XW-1:0] x;
        bit            known_bad;
    } pos_row_t;

    logic clk;
    logic rst_n;

    hem_in_if  #(.XW(XW)) pos_ch ();
    hem_out_if #(.VW(XW)) coord_ch ();
    hem_cfg_if            cfg_ch ();

    hilbert_evolvent_map_top #(
        .MAX_DIMS  (NDIM),
        .FRAC_BITS (FB)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pos   (pos_ch),
        .coord (coord_ch),
        .cfg   (cfg_ch)
    );

    // shadow of the three registers
    logic [3:0] sh_dims;
    logic [5:0] sh_levels;
    logic [1:0] sh_mode;

    coord_t coords_due[$];
    int     n_errors;
    bit     idle_on;
    bit     hold_req;
    int     hold_left;
    longint cycles;

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // cycle budget, counted at every rising edge
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // sign pattern, orientation and exit axis of sub-cube number s
    function automatic void cube_pattern(input longint unsigned s, input int n,
                                         inout int ax, inout int q,
                                         inout int u[NDIM], inout int v[NDIM]);
        longint unsigned cnt;
        longint unsigned half;
        longint unsigned rest;
        int prev;
        int cur;
        cnt = 64'd1 << n;
        if (s == 0)
        begin
            ax = n - 1;
            for (int i = 0; i < n; i++)
            begin
                u[i] = -1;
                v[i] = -1;
            end
        end
        else if (s == cnt - 1)
        begin
            ax = n - 1;
            for (int i = 0; i < n; i++)
            begin
                u[i] = -1;
                v[i] = -1;
            end
            u[0] = 1;
            v[0] = 1;
            v[n-1] = 1;
        end
        else
        begin
            half = cnt;
            rest = s;
            prev = -1;
            for (int i = 0; i < n; i++)
            begin
                half >>= 1;
                if (rest >= half)
                begin
                    if (rest == half && rest != 1)
                    begin
                        ax = i;
                        q = -1;
                    end
                    rest -= half;
                    cur = 1;
                end
                else
                begin
                    cur = -1;
                    if (rest == half - 1 && rest != 0)
                    begin
                        ax = i;
                        q = 1;
                    end
                end
                u[i] = -prev * cur;
                v[i] = u[i];
                prev = cur;
            end
            v[ax] = v[ax] * q;
            v[n-1] = -v[n-1];
        end
    endfunction

    // image point of one curve position under the shadow settings
    function automatic void map_position(input logic [XW-1:0] xin);
        logic [63:0]     y[NDIM];
        int              u[NDIM];
        int              v[NDIM];
        int              w[NDIM];
        int              n;
        int              m;
        int              nres;
        int              t;
        int              ax;
        int              k;
        int              it;
        int              q;
        int              tmp;
        int              sg;
        bit              bad;
        int              md;
        logic [XW-1:0]   x;
        longint unsigned s;
        longint unsigned dd;
        longint unsigned frac;
        longint unsigned digit;
        longint unsigned cnt;
        longint unsigned stp;
        longint unsigned c;
        logic [127:0]    prod;
        logic [63:0]     r;
        coord_t          cr;
        n = sh_dims;
        m = sh_levels;
        md = (sh_mode == 2'd3) ? int'(MODE_CENTER) : int'(sh_mode);
        nres = (n < 1) ? 1 : (n > NDIM) ? NDIM : n;
        bad = (n < 1) || (n > NDIM) || (m < 1) || (n * m > FB);
        ax = 0;
        k = 0;
        it = 0;
        frac = 0;
        digit = 0;
        for (int i = 0; i < NDIM; i++)
        begin
            y[i] = '0;
            u[i] = 0;
            v[i] = 0;
            w[i] = 1;
        end
        if (!bad)
        begin
            t = n * m;
            cnt = 64'd1 << n;
            x = (xin > POS_ONE) ? POS_ONE : xin;
            if (x == POS_ONE)
                s = (64'd1 << t) - 1;
            else if (md == MODE_LINEAR)
            begin
                prod = 128'(x) * 128'((64'd1 << t) - 1);
                s = prod[111:48];
                frac = 64'(prod[47:0]);
            end
            else if (md == MODE_NODE)
            begin
                prod = 128'(x) * 128'((64'd1 << t) - (64'd1 << (t - n)));
                dd = prod[111:48];
                s = (dd == 0) ? 64'd0 : dd + (dd - 1) / (cnt - 1);
            end
            else
                s = 64'(x) >> (FB - t);

            for (int j = 0; j < m; j++)
            begin
                stp = 64'd1 << (FB - 1 - j);
                digit = (s >> (n * (m - 1 - j))) & (cnt - 1);
                q = 0;
                cube_pattern(digit, n, ax, q, u, v);
                tmp = u[0]; u[0] = u[it]; u[it] = tmp;
                tmp = v[0]; v[0] = v[it]; v[it] = tmp;
                if (ax == 0)
                    ax = it;
                else if (ax == it)
                    ax = 0;
                if (q > 0 || (q == 0 && digit == 0))
                    k = ax;
                else if (q < 0)
                    k = (it == n - 1) ? 0 : n - 1;
                it = ax;
                for (int i = 0; i < n; i++)
                begin
                    u[i] = u[i] * w[i];
                    w[i] = -v[i] * w[i];
                    if (u[i] > 0)
                        y[i] += stp;
                    else if (u[i] < 0)
                        y[i] -= stp;
                end
            end

            if (md == MODE_LINEAR)
            begin
                c = (m == 1) ? frac : (frac + (64'd1 << (m - 2))) >> (m - 1);
                sg = ((digit == cnt - 1) ? -1 : 1) * u[k];
                if (sg > 0)
                    y[k] -= c;
                else if (sg < 0)
                    y[k] += c;
            end
            else if (md == MODE_NODE)
            begin
                stp = 64'd1 << (FB - m);
                for (int i = 0; i < n; i++)
                begin
                    if (u[i] > 0)
                        y[i] += stp;
                    else if (u[i] < 0)
                        y[i] -= stp;
                end
            end
        end
        for (int i = 0; i < nres; i++)
        begin
            r = y[i] + 64'd1;
            cr.idx = 4'(i);
            cr.value = bad ? '0 : XW'((r >> 1) | (r & 64'h8000_0000_0000_0000));
            cr.last = (i == nres - 1);
            cr.bad = bad;
            coords_due.push_back(cr);
        end
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [5:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            CFG_DIMS:   sh_dims   = val[3:0];
            CFG_LEVELS: sh_levels = val;
            CFG_MODE:   sh_mode   = val[1:0];
            default:    ;
        endcase
    endtask

    // block must be idle: drain, let it settle, then write all three
    task automatic apply_settings(input logic [3:0] d, input logic [5:0] l,
                                  input logic [1:0] md);
        wait (coords_due.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(CFG_DIMS, 6'(d));
        write_reg(CFG_LEVELS, l);
        write_reg(CFG_MODE, 6'(md));
        cfg_ch.valid <= 1'b0;
    endtask

    // offer one position, idling now and then; valid is only lowered when idling
    task automatic send_pos(input logic [XW-1:0] x, input bit known_bad);
        coord_t cr;
        int nres;
        if (idle_on && $urandom_range(99) < 19)
        begin
            pos_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 50);
        end
        pos_ch.valid <= 1'b1;
        pos_ch.x_position <= x;
        do
            @(posedge clk);
        while (!pos_ch.ready);
        if (known_bad)
        begin
            // unusable settings: clamped count of zero items, flag raised
            nres = (sh_dims < 1) ? 1 : (sh_dims > NDIM) ? NDIM : sh_dims;
            for (int i = 0; i < nres; i++)
            begin
                cr.idx = 4'(i);
                cr.value = '0;
                cr.last = (i == nres - 1);
                cr.bad = 1'b1;
                coords_due.push_back(cr);
            end
        end
        else
            map_position(x);
    endtask

    function automatic logic [XW-1:0] pick_pos();
        logic [XW-1:0] x;
        x = {1'b0, 16'($urandom), 32'($urandom)};
        case ($urandom_range(9))
            0: x = '0;
            1: x = POS_ONE;
            2: x = {1'b1, 16'($urandom), 32'($urandom)};   // above one, saturates
            3: x = POS_ONE - 1;
            default: ;
        endcase
        return x;
    endfunction

    // receiver: checks each item, stalls at random, and holds off on request
    initial
    begin
        coord_t ex;
        coord_ch.ready <= 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (coord_ch.valid && coord_ch.ready)
            begin
                if (coords_due.size() == 0)
                begin
                    $display("%0t unexpected item idx %0d value %h", $realtime,
                             coord_ch.coord_index, coord_ch.coord_value);
                    n_errors++;
                end
                else
                begin
                    ex = coords_due.pop_front();
                    if (coord_ch.coord_index !== ex.idx)
                    begin
                        $display("%0t coord_index exp %0d got %0d", $realtime,
                                 ex.idx, coord_ch.coord_index);
                        n_errors++;
                    end
                    if (coord_ch.coord_value !== ex.value)
                    begin
                        $display("%0t coord_value exp %h got %h", $realtime,
                                 ex.value, coord_ch.coord_value);
                        n_errors++;
                    end
                    if (coord_ch.last !== ex.last)
                    begin
                        $display("%0t last exp %b got %b", $realtime, ex.last, coord_ch.last);
                        n_errors++;
                    end
                    if (coord_ch.bad_setting !== ex.bad)
                    begin
                        $display("%0t bad_setting exp %b got %b", $realtime,
                                 ex.bad, coord_ch.bad_setting);
                        n_errors++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                coord_ch.ready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
                coord_ch.ready <= 1'b0;
            end
            else
                coord_ch.ready <= !(idle_on && $urandom_range(99) < 19);
        end
    end

    // directed rows: reset settings, extremes of size, every mode, unusable settings
    pos_row_t rows[] = '{
        '{4'd2,  6'd10, 2'd0, 49'h0,                 1'b0},
        '{4'd2,  6'd10, 2'd0, POS_ONE,               1'b0},
        '{4'd2,  6'd10, 2'd0, 49'h1_FFFF_FFFF_FFFF,  1'b0},
        '{4'd2,  6'd10, 2'd0, 49'h0_8000_0000_0000,  1'b0},
        '{4'd1,  6'd1,  2'd0, 49'h0,                 1'b0},
        '{4'd1,  6'd1,  2'd0, POS_ONE,               1'b0},
        '{4'd1,  6'd48, 2'd1, 49'h0_5555_5555_5555,  1'b0},
        '{4'd1,  6'd48, 2'd1, 49'h0_FFFF_FFFF_FFFF,  1'b0},
        '{4'd10, 6'd4,  2'd2, 49'h0,                 1'b0},
        '{4'd10, 6'd4,  2'd2, POS_ONE,               1'b0},
        '{4'd10, 6'd4,  2'd2, 49'h0_8000_0000_0001,  1'b0},
        '{4'd2,  6'd24, 2'd1, 49'h0_FFFF_FFFF_FFFF,  1'b0},
        '{4'd2,  6'd24, 2'd1, 49'h0_0000_0000_0001,  1'b0},
        '{4'd3,  6'd16, 2'd2, 49'h0_AAAA_AAAA_AAAA,  1'b0},
        '{4'd3,  6'd16, 2'd2, 49'h0_0000_0000_0001,  1'b0},
        '{4'd4,  6'd12, 2'd3, 49'h0_1234_5678_9ABC,  1'b0},
        '{4'd8,  6'd6,  2'd1, 49'h0_7FFF_0000_FFFF,  1'b0},
        '{4'd0,  6'd10, 2'd0, 49'h0_4000_0000_0000,  1'b1},
        '{4'd11, 6'd1,  2'd0, 49'h0_4000_0000_0000,  1'b1},
        '{4'd15, 6'd3,  2'd1, POS_ONE,               1'b1},
        '{4'd5,  6'd0,  2'd0, 49'h0_2000_0000_0000,  1'b1},
        '{4'd7,  6'd7,  2'd2, 49'h0_2000_0000_0000,  1'b1},
        '{4'd1,  6'd63, 2'd0, 49'h1_0000_0000_0001,  1'b1}
    };

    // main sequence
    initial
    begin
        logic [3:0] d;
        logic [5:0] l;
        n_errors = 0;
        idle_on = 1'b1;
        hold_req = 1'b0;
        rst_n = 1'b0;
        pos_ch.valid <= 1'b0;
        pos_ch.x_position <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_DIMS;
        cfg_ch.data <= '0;
        sh_dims = 4'd2;
        sh_levels = 6'd10;
        sh_mode = MODE_CENTER;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // a write to the spare index must change nothing
        write_reg(CFG_SPARE, 6'h3F);
        cfg_ch.valid <= 1'b0;

        // first rows run on the reset settings, no writes
        foreach (rows[i])
        begin
            if (rows[i].dims != sh_dims || rows[i].levels != sh_levels ||
                rows[i].mode != sh_mode)
            begin
                pos_ch.valid <= 1'b0;
                apply_settings(rows[i].dims, rows[i].levels, rows[i].mode);
            end
            send_pos(rows[i].x, rows[i].known_bad);
        end

        // random phases of 20 positions on fresh settings
        for (int ph = 0; ph < 24; ph++)
        begin
            if ($urandom_range(9) == 0)
            begin
                d = 4'($urandom_range(15));
                l = 6'($urandom_range(63));
            end
            else
            begin
                d = 4'($urandom_range(1, NDIM));
                l = ($urandom_range(4) == 0) ? 6'(FB / d) : 6'($urandom_range(1, FB / d));
            end
            pos_ch.valid <= 1'b0;
            apply_settings(d, l, 2'($urandom_range(3)));
            idle_on = (ph != 5);   // one phase runs flat out on both sides
            if (ph == 3)
                hold_req = 1'b1;   // long sink hold-off while positions keep coming
            for (int i = 0; i < 20; i++)
                send_pos(pick_pos(), 1'b0);
        end
        idle_on = 1'b1;
        pos_ch.valid <= 1'b0;

        wait (coords_due.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
